### design/lups_pkg.sv
`default_nettype none
package lups_pkg;

    localparam int MAX_N     = 8;
    localparam int FRAC_BITS = 16;
    localparam int COLS      = MAX_N + 1;
    localparam int MEM_DEPTH = MAX_N * COLS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int ROW_W     = $clog2(MAX_N);
    localparam int CNT_W     = $clog2(MAX_N + 1);
    localparam int COL_W     = 4;
    localparam int SIZE_W    = 4;
    localparam int THR_W     = 31;
    localparam int DATA_W    = 32;
    localparam int ACC_W     = DATA_W + ROW_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_THRESHOLD = CFG_IDX_W'(1);

    typedef logic [4:0] op_t;

    localparam op_t OP_NOP       = 5'd0;
    localparam op_t OP_LOAD      = 5'd1;
    localparam op_t OP_CP_WR     = 5'd2;
    localparam op_t OP_INIT      = 5'd3;
    localparam op_t OP_BEST_INIT = 5'd4;
    localparam op_t OP_BEST_CMP  = 5'd5;
    localparam op_t OP_TMP       = 5'd6;
    localparam op_t OP_WR_Q      = 5'd7;
    localparam op_t OP_WR_TMP    = 5'd8;
    localparam op_t OP_PERM_SWAP = 5'd9;
    localparam op_t OP_PIV       = 5'd10;
    localparam op_t OP_DIV_F     = 5'd11;
    localparam op_t OP_F_LD      = 5'd12;
    localparam op_t OP_MUL_F     = 5'd13;
    localparam op_t OP_ELIM_WR   = 5'd14;
    localparam op_t OP_ACC_CLR   = 5'd15;
    localparam op_t OP_MUL_SOL   = 5'd16;
    localparam op_t OP_ACC_ADD   = 5'd17;
    localparam op_t OP_BSUB      = 5'd18;
    localparam op_t OP_DIV_X     = 5'd19;
    localparam op_t OP_SOL_WR    = 5'd20;
    localparam op_t OP_DET_INIT  = 5'd21;
    localparam op_t OP_MUL_DET   = 5'd22;
    localparam op_t OP_DET_UPD   = 5'd23;
    localparam op_t OP_DET_SIGN  = 5'd24;
    localparam op_t OP_OUT       = 5'd25;
    localparam op_t OP_OUT_SING  = 5'd26;

    typedef struct packed {
        op_t               op;
        logic              rd_w;
        logic              rd_a;
        logic [ADDR_W-1:0] raddr;
        logic [ADDR_W-1:0] waddr;
        logic [ROW_W-1:0]  k;
        logic [ROW_W-1:0]  p;
        logic [ROW_W-1:0]  idx;
        logic              last;
        logic [THR_W-1:0]  thr;
    } cmd_t;

    typedef struct packed {
        logic mag_gt;
        logic below_thr;
        logic div_done;
    } stat_t;

    localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7fff_ffff;
    localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        if (v > S32_MAX) begin
            sat32 = S32_MAX[DATA_W-1:0];
        end else if (v < S32_MIN) begin
            sat32 = S32_MIN[DATA_W-1:0];
        end else begin
            sat32 = v[DATA_W-1:0];
        end
    endfunction

    // Round half up, then floor shift by the fraction width.
    function automatic logic signed [DATA_W-1:0] rnd_mul(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + (64'sd1 <<< (FRAC_BITS - 1));
        rnd_mul = sat32(t >>> FRAC_BITS);
    endfunction

    function automatic logic [DATA_W:0] mag32(input logic signed [DATA_W-1:0] v);
        logic signed [DATA_W:0] e;
        e = {v[DATA_W-1], v};
        mag32 = e[DATA_W] ? -e : e;
    endfunction

    function automatic logic [ADDR_W-1:0] maddr(input logic [CNT_W-1:0] r,
                                                input logic [CNT_W-1:0] c);
        logic [ADDR_W-1:0] rr;
        rr = ADDR_W'(r);
        maddr = rr * ADDR_W'(COLS) + ADDR_W'(c);
    endfunction

endpackage
`default_nettype wire

### design/lups_div.sv
`default_nettype none
module lups_div (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire logic signed [lups_pkg::DATA_W-1:0]  num,
    input  wire logic signed [lups_pkg::DATA_W-1:0]  den,
    output logic                                     done,
    output logic signed [lups_pkg::DATA_W-1:0]       quo
);
    import lups_pkg::*;

    localparam int NW = DATA_W + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg;
    logic [NW-1:0]     nq_reg, nq_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] ub_reg;
    logic              neg_reg, zz_reg;
    logic signed [DATA_W-1:0] quo_reg;

    logic [DATA_W:0]    trial;
    logic               qb;
    logic signed [63:0] qs;
    logic [DATA_W:0]    ua, ubw;

    // One quotient bit per cycle, restoring, on magnitudes.
    always_comb begin
        trial = {rem_reg, nq_reg[NW-1]};
        qb    = (trial >= {1'b0, ub_reg});
        rem_next = qb ? DATA_W'(trial - {1'b0, ub_reg}) : trial[DATA_W-1:0];
        nq_next  = {nq_reg[NW-2:0], qb};
        qs       = $signed(64'(nq_next));
        ua       = mag32(num);
        ubw      = mag32(den);
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
        end else if (busy_reg && cnt_reg == CW'(1)) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            nq_reg  <= {ua[DATA_W-1:0], {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            ub_reg  <= ubw[DATA_W-1:0];
            cnt_reg <= CW'(NW);
            neg_reg <= num[DATA_W-1] ^ den[DATA_W-1];
            zz_reg  <= (num == '0) && (den == '0);
        end else if (busy_reg) begin
            nq_reg  <= nq_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                if (zz_reg) begin
                    quo_reg <= '0;
                end else begin
                    quo_reg <= sat32(neg_reg ? -qs : qs);
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire

### design/lups_dp.sv
`default_nettype none
module lups_dp (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire lups_pkg::cmd_t                      cmd,
    output lups_pkg::stat_t                          stat,
    input  wire logic signed [lups_pkg::DATA_W-1:0]  s_element_value,
    output logic [lups_pkg::ROW_W-1:0]               m_result_row,
    output logic signed [lups_pkg::DATA_W-1:0]       m_solution_value,
    output logic [lups_pkg::ROW_W-1:0]               m_perm_entry,
    output logic signed [lups_pkg::DATA_W-1:0]       m_determinant,
    output logic                                     m_singular,
    output logic                                     m_last_result
);
    import lups_pkg::*;

    logic signed [DATA_W-1:0] a_mem [MEM_DEPTH];
    logic signed [DATA_W-1:0] w_mem [MEM_DEPTH];
    logic signed [DATA_W-1:0] a_q, w_q;

    logic signed [DATA_W-1:0] tmp_reg, piv_reg, f_reg, det_reg;
    logic [DATA_W:0]          best_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [63:0]       prod_reg;
    logic signed [DATA_W-1:0] sol_reg [MAX_N];
    logic [ROW_W-1:0]         perm_reg [MAX_N];
    logic                     parity_reg;

    logic [ROW_W-1:0]         row_o_reg, perm_o_reg;
    logic signed [DATA_W-1:0] sol_o_reg, det_o_reg;
    logic                     sing_o_reg, last_o_reg;

    logic [DATA_W:0]          w_mag;
    logic signed [DATA_W-1:0] prod_rnd, mul_a, mul_b, w_wdata, div_num, div_den, div_q;
    logic                     w_we, div_start, div_done;

    always_comb begin
        w_mag    = mag32(w_q);
        prod_rnd = rnd_mul(prod_reg);
        mul_a    = f_reg;
        mul_b    = w_q;
        case (cmd.op)
            OP_MUL_SOL: begin
                mul_a = w_q;
                mul_b = sol_reg[cmd.idx];
            end
            OP_MUL_DET: mul_a = det_reg;
            default: mul_a = f_reg;
        endcase
        w_we    = 1'b1;
        w_wdata = a_q;
        case (cmd.op)
            OP_CP_WR:   w_wdata = a_q;
            OP_WR_Q:    w_wdata = w_q;
            OP_WR_TMP:  w_wdata = tmp_reg;
            OP_ELIM_WR: w_wdata = sat32(64'(w_q) - 64'(prod_rnd));
            default:    w_we = 1'b0;
        endcase
        div_start = (cmd.op == OP_DIV_F) || (cmd.op == OP_DIV_X);
        div_num   = (cmd.op == OP_DIV_F) ? w_q : tmp_reg;
        div_den   = (cmd.op == OP_DIV_F) ? piv_reg : w_q;
        stat.mag_gt    = w_mag > best_reg;
        stat.below_thr = best_reg < {2'b00, cmd.thr};
        stat.div_done  = div_done;
    end

    lups_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_q)
    );

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            a_mem[cmd.waddr] <= s_element_value;
        end
        if (cmd.rd_a) begin
            a_q <= a_mem[cmd.raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (w_we) begin
            w_mem[cmd.waddr] <= w_wdata;
        end
        if (cmd.rd_w) begin
            w_q <= w_mem[cmd.raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_N; i++) begin
                perm_reg[i] <= ROW_W'(i);
            end
            parity_reg <= 1'b0;
        end else if (cmd.op == OP_INIT) begin
            for (int i = 0; i < MAX_N; i++) begin
                perm_reg[i] <= ROW_W'(i);
            end
            parity_reg <= 1'b0;
        end else if (cmd.op == OP_PERM_SWAP) begin
            perm_reg[cmd.k] <= perm_reg[cmd.p];
            perm_reg[cmd.p] <= perm_reg[cmd.k];
            parity_reg      <= ~parity_reg;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_BEST_INIT: best_reg <= w_mag;
            OP_BEST_CMP:  if (w_mag > best_reg) best_reg <= w_mag;
            OP_TMP:       tmp_reg <= w_q;
            OP_PIV:       piv_reg <= w_q;
            OP_F_LD:      f_reg <= div_q;
            OP_MUL_F, OP_MUL_SOL, OP_MUL_DET: prod_reg <= mul_a * mul_b;
            OP_ACC_CLR:   acc_reg <= '0;
            OP_ACC_ADD:   acc_reg <= acc_reg + ACC_W'(prod_rnd);
            OP_BSUB:      tmp_reg <= sat32(64'(w_q) - 64'(acc_reg));
            OP_SOL_WR:    sol_reg[cmd.idx] <= div_q;
            OP_DET_INIT:  det_reg <= sat32(64'sd1 <<< FRAC_BITS);
            OP_DET_UPD:   det_reg <= prod_rnd;
            OP_DET_SIGN:  if (parity_reg) det_reg <= sat32(-64'(det_reg));
            OP_OUT: begin
                row_o_reg  <= cmd.idx;
                sol_o_reg  <= sol_reg[cmd.idx];
                perm_o_reg <= perm_reg[cmd.idx];
                det_o_reg  <= det_reg;
                sing_o_reg <= 1'b0;
                last_o_reg <= cmd.last;
            end
            OP_OUT_SING: begin
                row_o_reg  <= '0;
                sol_o_reg  <= '0;
                perm_o_reg <= '0;
                det_o_reg  <= '0;
                sing_o_reg <= 1'b1;
                last_o_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    assign m_result_row     = row_o_reg;
    assign m_solution_value = sol_o_reg;
    assign m_perm_entry     = perm_o_reg;
    assign m_determinant    = det_o_reg;
    assign m_singular       = sing_o_reg;
    assign m_last_result    = last_o_reg;

endmodule
`default_nettype wire

### design/lups_ctrl.sv
`default_nettype none
module lups_ctrl (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [lups_pkg::ROW_W-1:0]       s_row_index,
    input  wire logic [lups_pkg::COL_W-1:0]       s_col_index,
    input  wire logic                             s_last_element,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    input  wire logic                             cfg_we,
    input  wire logic [lups_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [lups_pkg::THR_W-1:0]       cfg_wdata,
    output lups_pkg::cmd_t                        cmd,
    input  wire lups_pkg::stat_t                  stat
);
    import lups_pkg::*;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_INIT     = 5'd1;
    localparam logic [4:0] S_CP_RD    = 5'd2;
    localparam logic [4:0] S_CP_WR    = 5'd3;
    localparam logic [4:0] S_PV_RD    = 5'd4;
    localparam logic [4:0] S_PV_INIT  = 5'd5;
    localparam logic [4:0] S_PV_NEXT  = 5'd6;
    localparam logic [4:0] S_PV_CMP   = 5'd7;
    localparam logic [4:0] S_PV_CHK   = 5'd8;
    localparam logic [4:0] S_SW_RDK   = 5'd9;
    localparam logic [4:0] S_SW_TMP   = 5'd10;
    localparam logic [4:0] S_SW_WK    = 5'd11;
    localparam logic [4:0] S_SW_WP    = 5'd12;
    localparam logic [4:0] S_SW_PERM  = 5'd13;
    localparam logic [4:0] S_PIV_RD   = 5'd14;
    localparam logic [4:0] S_PIV_LD   = 5'd15;
    localparam logic [4:0] S_EL_ROW   = 5'd16;
    localparam logic [4:0] S_EL_DIV   = 5'd17;
    localparam logic [4:0] S_EL_DWAIT = 5'd18;
    localparam logic [4:0] S_EL_RDK   = 5'd19;
    localparam logic [4:0] S_EL_MUL   = 5'd20;
    localparam logic [4:0] S_EL_WR    = 5'd21;
    localparam logic [4:0] S_BS_INIT  = 5'd22;
    localparam logic [4:0] S_BS_NEXT  = 5'd23;
    localparam logic [4:0] S_BS_MUL   = 5'd24;
    localparam logic [4:0] S_BS_ACC   = 5'd25;
    localparam logic [4:0] S_BS_SUB   = 5'd26;
    localparam logic [4:0] S_BS_DIV   = 5'd27;
    localparam logic [4:0] S_BS_DWAIT = 5'd28;
    localparam logic [4:0] S_DT_INIT  = 5'd29;
    localparam logic [4:0] S_DT_RD    = 5'd30;
    localparam logic [4:0] S_DT_MUL   = 5'd31;

    // Determinant update, sign and output states live in a second code group.
    logic             grp_reg, grp_next;
    localparam logic [4:0] S2_DT_UPD   = 5'd0;
    localparam logic [4:0] S2_DT_SIGN  = 5'd1;
    localparam logic [4:0] S2_OUT_LD   = 5'd2;
    localparam logic [4:0] S2_OUT_WAIT = 5'd3;

    logic [4:0]        state_reg, state_next;
    logic [CNT_W-1:0]  k_reg, k_next, i_reg, i_next, j_reg, j_next, p_reg, p_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              out_last_reg, out_last_next;
    logic [SIZE_W-1:0] size_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [CNT_W-1:0]  n;
    logic [CNT_W-1:0]  n_m1;
    logic              load_ok;
    logic              out_wait;

    always_comb begin
        if (size_reg == '0) begin
            n = CNT_W'(1);
        end else if (size_reg > SIZE_W'(MAX_N)) begin
            n = CNT_W'(MAX_N);
        end else begin
            n = CNT_W'(size_reg);
        end
        n_m1    = n - CNT_W'(1);
        load_ok = (5'(s_row_index) < 5'(n)) && (5'(s_col_index) <= 5'(n));
        out_wait = grp_reg && (state_reg == S2_OUT_WAIT);
    end

    always_comb begin
        state_next    = state_reg;
        grp_next      = grp_reg;
        k_next        = k_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        p_next        = p_reg;
        cnt_next      = cnt_reg;
        out_last_next = out_last_reg;
        cmd           = '0;
        cmd.thr       = thr_reg;
        cmd.k         = k_reg[ROW_W-1:0];
        cmd.p         = p_reg[ROW_W-1:0];
        s_ready       = 1'b0;
        m_valid       = out_wait;
        if (!grp_reg) begin
            case (state_reg)
                S_IDLE: begin
                    s_ready = 1'b1;
                    if (s_valid) begin
                        if (load_ok) begin
                            cmd.op    = OP_LOAD;
                            cmd.waddr = maddr(CNT_W'(s_row_index), CNT_W'(s_col_index));
                        end
                        if (s_last_element) begin
                            state_next = S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    cmd.op     = OP_INIT;
                    cnt_next   = '0;
                    state_next = S_CP_RD;
                end
                S_CP_RD: begin
                    cmd.rd_a   = 1'b1;
                    cmd.raddr  = cnt_reg;
                    state_next = S_CP_WR;
                end
                S_CP_WR: begin
                    cmd.op    = OP_CP_WR;
                    cmd.waddr = cnt_reg;
                    if (cnt_reg == ADDR_W'(MEM_DEPTH - 1)) begin
                        k_next     = '0;
                        state_next = S_PV_RD;
                    end else begin
                        cnt_next   = cnt_reg + ADDR_W'(1);
                        state_next = S_CP_RD;
                    end
                end
                S_PV_RD: begin
                    cmd.rd_w   = 1'b1;
                    cmd.raddr  = maddr(k_reg, k_reg);
                    i_next     = k_reg + CNT_W'(1);
                    state_next = S_PV_INIT;
                end
                S_PV_INIT: begin
                    cmd.op     = OP_BEST_INIT;
                    p_next     = k_reg;
                    state_next = S_PV_NEXT;
                end
                S_PV_NEXT: begin
                    if (i_reg < n) begin
                        cmd.rd_w   = 1'b1;
                        cmd.raddr  = maddr(i_reg, k_reg);
                        state_next = S_PV_CMP;
                    end else begin
                        state_next = S_PV_CHK;
                    end
                end
                S_PV_CMP: begin
                    cmd.op = OP_BEST_CMP;
                    if (stat.mag_gt) begin
                        p_next = i_reg;
                    end
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_PV_NEXT;
                end
                S_PV_CHK: begin
                    if (stat.below_thr) begin
                        cmd.op        = OP_OUT_SING;
                        out_last_next = 1'b1;
                        grp_next      = 1'b1;
                        state_next    = S2_OUT_WAIT;
                    end else if (p_reg != k_reg) begin
                        j_next     = '0;
                        state_next = S_SW_RDK;
                    end else begin
                        state_next = S_PIV_RD;
                    end
                end
                S_SW_RDK: begin
                    cmd.rd_w   = 1'b1;
                    cmd.raddr  = maddr(k_reg, j_reg);
                    state_next = S_SW_TMP;
                end
                S_SW_TMP: begin
                    cmd.op     = OP_TMP;
                    cmd.rd_w   = 1'b1;
                    cmd.raddr  = maddr(p_reg, j_reg);
                    state_next = S_SW_WK;
                end
                S_SW_WK: begin
                    cmd.op     = OP_WR_Q;
                    cmd.waddr  = maddr(k_reg, j_reg);
                    state_next = S_SW_WP;
                end
                S_SW_WP: begin
                    cmd.op    = OP_WR_TMP;
                    cmd.waddr = maddr(p_reg, j_reg);
                    if (j_reg == n) begin
                        state_next = S_SW_PERM;
                    end else begin
                        j_next     = j_reg + CNT_W'(1);
                        state_next = S_SW_RDK;
                    end
                end
                S_SW_PERM: begin
                    cmd.op     = OP_PERM_SWAP;
                    state_next = S_PIV_RD;
                end
                S_PIV_RD: begin
                    cmd.rd_w   = 1'b1;
                    cmd.raddr  = maddr(k_reg, k_reg);
                    state_next = S_PIV_LD;
                end
                S_PIV_LD: begin
                    cmd.op     = OP_PIV;
                    i_next     = k_reg + CNT_W'(1);
                    state_next = S_EL_ROW;
                end
                S_EL_ROW: begin
                    if (i_reg < n) begin
                        cmd.rd_w   = 1'b1;
                        cmd.raddr  = maddr(i_reg, k_reg);
                        state_next = S_EL_DIV;
                    end else if (k_reg == n_m1) begin
                        i_next     = n_m1;
                        state_next = S_BS_INIT;
                    end else begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = S_PV_RD;
                    end
                end
                S_EL_DIV: begin
                    cmd.op     = OP_DIV_F;
                    state_next = S_EL_DWAIT;
                end
                S_EL_DWAIT: begin
                    if (stat.div_done) begin
                        cmd.op     = OP_F_LD;
                        j_next     = k_reg + CNT_W'(1);
                        state_next = S_EL_RDK;
                    end
                end
                S_EL_RDK: begin
                    cmd.rd_w   = 1'b1;
                    cmd.raddr  = maddr(k_reg, j_reg);
                    state_next = S_EL_MUL;
                end
                S_EL_MUL: begin
                    cmd.op     = OP_MUL_F;
                    cmd.rd_w   = 1'b1;
                    cmd.raddr  = maddr(i_reg, j_reg);
                    state_next = S_EL_WR;
                end
                S_EL_WR: begin
                    cmd.op    = OP_ELIM_WR;
                    cmd.waddr = maddr(i_reg, j_reg);
                    if (j_reg == n) begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = S_EL_ROW;
                    end else begin
                        j_next     = j_reg + CNT_W'(1);
                        state_next = S_EL_RDK;
                    end
                end
                S_BS_INIT: begin
                    cmd.op     = OP_ACC_CLR;
                    j_next     = i_reg + CNT_W'(1);
                    state_next = S_BS_NEXT;
                end
                S_BS_NEXT: begin
                    cmd.rd_w = 1'b1;
                    if (j_reg < n) begin
                        cmd.raddr  = maddr(i_reg, j_reg);
                        state_next = S_BS_MUL;
                    end else begin
                        cmd.raddr  = maddr(i_reg, n);
                        state_next = S_BS_SUB;
                    end
                end
                S_BS_MUL: begin
                    cmd.op     = OP_MUL_SOL;
                    cmd.idx    = j_reg[ROW_W-1:0];
                    state_next = S_BS_ACC;
                end
                S_BS_ACC: begin
                    cmd.op     = OP_ACC_ADD;
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_BS_NEXT;
                end
                S_BS_SUB: begin
                    cmd.op     = OP_BSUB;
                    cmd.rd_w   = 1'b1;
                    cmd.raddr  = maddr(i_reg, i_reg);
                    state_next = S_BS_DIV;
                end
                S_BS_DIV: begin
                    cmd.op     = OP_DIV_X;
                    state_next = S_BS_DWAIT;
                end
                S_BS_DWAIT: begin
                    if (stat.div_done) begin
                        cmd.op  = OP_SOL_WR;
                        cmd.idx = i_reg[ROW_W-1:0];
                        if (i_reg == '0) begin
                            state_next = S_DT_INIT;
                        end else begin
                            i_next     = i_reg - CNT_W'(1);
                            state_next = S_BS_INIT;
                        end
                    end
                end
                S_DT_INIT: begin
                    cmd.op     = OP_DET_INIT;
                    i_next     = '0;
                    state_next = S_DT_RD;
                end
                S_DT_RD: begin
                    cmd.rd_w   = 1'b1;
                    cmd.raddr  = maddr(i_reg, i_reg);
                    state_next = S_DT_MUL;
                end
                S_DT_MUL: begin
                    cmd.op     = OP_MUL_DET;
                    grp_next   = 1'b1;
                    state_next = S2_DT_UPD;
                end
                default: begin
                    state_next = S_IDLE;
                end
            endcase
        end else begin
            case (state_reg)
                S2_DT_UPD: begin
                    cmd.op = OP_DET_UPD;
                    if (i_reg == n_m1) begin
                        state_next = S2_DT_SIGN;
                    end else begin
                        i_next     = i_reg + CNT_W'(1);
                        grp_next   = 1'b0;
                        state_next = S_DT_RD;
                    end
                end
                S2_DT_SIGN: begin
                    cmd.op     = OP_DET_SIGN;
                    i_next     = '0;
                    state_next = S2_OUT_LD;
                end
                S2_OUT_LD: begin
                    cmd.op        = OP_OUT;
                    cmd.idx       = i_reg[ROW_W-1:0];
                    cmd.last      = (i_reg == n_m1);
                    out_last_next = (i_reg == n_m1);
                    state_next    = S2_OUT_WAIT;
                end
                S2_OUT_WAIT: begin
                    if (m_ready) begin
                        if (out_last_reg) begin
                            grp_next   = 1'b0;
                            state_next = S_IDLE;
                        end else begin
                            i_next     = i_reg + CNT_W'(1);
                            state_next = S2_OUT_LD;
                        end
                    end
                end
                default: begin
                    grp_next   = 1'b0;
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            grp_reg      <= 1'b0;
            out_last_reg <= 1'b0;
            size_reg     <= SIZE_W'(8);
            thr_reg      <= THR_W'(1);
        end else begin
            state_reg    <= state_next;
            grp_reg      <= grp_next;
            out_last_reg <= out_last_next;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_MATRIX_SIZE:     size_reg <= cfg_wdata[SIZE_W-1:0];
                    REG_PIVOT_THRESHOLD: thr_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        k_reg   <= k_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        p_reg   <= p_next;
        cnt_reg <= cnt_next;
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is offered");

    a_solve_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_element) |=> !s_ready)
        else $error("input still ready after the final element");

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && out_last_reg) |=> (s_ready && !m_valid))
        else $error("controller did not return to idle after the last result");

    a_pivot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (!grp_reg && state_reg == S_SW_PERM) |-> (p_reg > k_reg && p_reg < n))
        else $error("row swap with an invalid pivot row");
`endif

endmodule
`default_nettype wire

### design/lu_pivot_linear_solver_top.sv
`default_nettype none
// Linear system solver with LU elimination and partial pivoting, signed Q16.16.
// The input channel (s_*) takes one element of the augmented matrix [A|b] per
// transfer, addressed by row and column; the column equal to the matrix size
// carries b. Elements outside the configured size are dropped. A transfer with
// s_last_element set starts the solve on a working copy of the loaded matrix;
// loaded elements persist across solves.
// The result channel (m_*) then carries either one transfer flagged singular, or
// one transfer per row with x, the permutation entry and the determinant; the
// last transfer of a run has m_last_result set.
// Loads are accepted back to back while idle. A solve first copies all 72 words
// of the loaded matrix into working memory, then runs elimination and back
// substitution through single-ported memory, with n*(n+1)/2 divisions in the
// bit-serial divider.
// One result waits in the output register per transfer; while m_ready is low the
// block simply holds it and accepts no new input until the run has drained.
// Configuration writes (cfg_*) take effect at once and are meant for idle time.
// Reset (synchronous, active low) sets size 8, threshold 1, identity
// permutation and an idle controller; matrix contents stay undefined.
module lu_pivot_linear_solver_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [lups_pkg::ROW_W-1:0]          s_row_index,
    input  wire logic [lups_pkg::COL_W-1:0]          s_col_index,
    input  wire logic signed [lups_pkg::DATA_W-1:0]  s_element_value,
    input  wire logic                                s_last_element,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [lups_pkg::ROW_W-1:0]               m_result_row,
    output logic signed [lups_pkg::DATA_W-1:0]       m_solution_value,
    output logic [lups_pkg::ROW_W-1:0]               m_perm_entry,
    output logic signed [lups_pkg::DATA_W-1:0]       m_determinant,
    output logic                                     m_singular,
    output logic                                     m_last_result,
    input  wire logic                                cfg_we,
    input  wire logic [lups_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  wire logic [lups_pkg::THR_W-1:0]          cfg_wdata
);
    import lups_pkg::*;

    // The controller sequences every memory access; the datapath only executes.
    cmd_t  cmd;
    stat_t stat;

    lups_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_row_index    (s_row_index),
        .s_col_index    (s_col_index),
        .s_last_element (s_last_element),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .cmd            (cmd),
        .stat           (stat)
    );

    lups_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_element_value  (s_element_value),
        .m_result_row     (m_result_row),
        .m_solution_value (m_solution_value),
        .m_perm_entry     (m_perm_entry),
        .m_determinant    (m_determinant),
        .m_singular       (m_singular),
        .m_last_result    (m_last_result)
    );

endmodule
`default_nettype wire
